// ===== rtl/core/dtc_pkg.sv =====
// Shared types, constants and codes of the decision tree packet classifier.
package dtc_pkg;

    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_W      = 14;
    localparam int ID_W        = 17;
    localparam int RULE_W      = 16;
    localparam int TC_W        = 3;
    localparam int SEL_W       = 3;
    localparam int THR_W       = 32;
    localparam int ALU_W       = 32;
    localparam int SPLIT_W     = SEL_W + THR_W;
    localparam int CHILD_W     = 2 * ID_W;

    localparam int TREES_DEFAULT          = 4;
    localparam int NODES_PER_TREE_DEFAULT = 4096;
    localparam int MAX_WALK_STEPS_DEFAULT = 32;

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic REG_DEFAULT_RULE = 1'b0;
    localparam logic REG_TREE_COUNT   = 1'b1;

    localparam logic [SEL_W-1:0] SEL_SRC_IP   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_DST_IP   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_SRC_PORT = 3'd2;
    localparam logic [SEL_W-1:0] SEL_DST_PORT = 3'd3;
    localparam logic [SEL_W-1:0] SEL_PROTOCOL = 3'd4;
    localparam logic [SEL_W-1:0] SEL_EXTRA    = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK_IDX,
        S_CHECK_ADDR,
        S_COMPARE,
        S_LEAF,
        S_MIN
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             borrow;
    } alu_rsp_t;

endpackage

// ===== rtl/core/dtc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/dtc_alu.sv =====
// Shared subtract and compare unit used by every step of the tree walk.
module dtc_alu (
    input  dtc_pkg::alu_req_t req,
    output dtc_pkg::alu_rsp_t rsp
);

    import dtc_pkg::*;

    logic [ALU_W:0] result;

    assign result     = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.diff   = result[ALU_W-1:0];
    assign rsp.borrow = result[ALU_W];

endmodule

// ===== rtl/core/dtc_seq.sv =====
// Walk sequencer: steps through each tree node by node using the shared unit.
module dtc_seq #(
    parameter int TREES          = dtc_pkg::TREES_DEFAULT,
    parameter int NODES_PER_TREE = dtc_pkg::NODES_PER_TREE_DEFAULT,
    parameter int MAX_WALK_STEPS = dtc_pkg::MAX_WALK_STEPS_DEFAULT,
    parameter int MEM_DEPTH      = dtc_pkg::STORE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         classify_start,
    input  logic [31:0]                  src_ip,
    input  logic [31:0]                  dst_ip,
    input  logic [15:0]                  src_port,
    input  logic [15:0]                  dst_port,
    input  logic [7:0]                   protocol,
    input  logic [7:0]                   extra_field,
    input  logic [dtc_pkg::RULE_W-1:0]   default_rule,
    input  logic [dtc_pkg::TC_W-1:0]     tree_count,
    input  logic [dtc_pkg::SPLIT_W-1:0]  split_data,
    input  logic [dtc_pkg::CHILD_W-1:0]  child_data,
    input  dtc_pkg::alu_rsp_t            alu_rsp,
    output dtc_pkg::alu_req_t            alu_req,
    output logic                         rd_en,
    output logic [$clog2(MEM_DEPTH)-1:0] rd_addr,
    output logic                         busy,
    output logic                         done,
    output logic [dtc_pkg::RULE_W-1:0]   match_rule,
    output logic                         walk_error
);

    import dtc_pkg::*;

    localparam int TW  = $clog2(TREES + 1);
    localparam int BW  = $clog2(TREES * NODES_PER_TREE + 1);
    localparam int SW  = $clog2(MAX_WALK_STEPS + 1);
    localparam int MAW = $clog2(MEM_DEPTH);

    state_t state_reg, state_next;

    logic [31:0]       src_ip_reg, src_ip_next;
    logic [31:0]       dst_ip_reg, dst_ip_next;
    logic [15:0]       src_port_reg, src_port_next;
    logic [15:0]       dst_port_reg, dst_port_next;
    logic [7:0]        protocol_reg, protocol_next;
    logic [7:0]        extra_reg, extra_next;
    logic [TW-1:0]     trees_reg, trees_next;
    logic [TW-1:0]     tree_reg, tree_next;
    logic [BW-1:0]     base_reg, base_next;
    logic [ID_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [SW-1:0]     steps_reg, steps_next;
    logic [RULE_W-1:0] pri_reg, pri_next;
    logic              done_reg, done_next;
    logic [RULE_W-1:0] match_reg, match_next;
    logic              error_reg, error_next;

    logic [TW-1:0]     trees_sat;
    logic [ID_W-1:0]   offset;
    logic [ALU_W-1:0]  addr_sum;
    logic [SEL_W-1:0]  node_sel;
    logic [THR_W-1:0]  node_thr;
    logic [ID_W-1:0]   node_left;
    logic [ID_W-1:0]   node_right;
    logic [ALU_W-1:0]  field_val;
    logic              last_tree;
    logic              steps_full;

    assign offset     = ID_W'(default_rule) + ID_W'(1);
    assign addr_sum   = ALU_W'(base_reg) + ALU_W'(idx_reg);
    assign node_sel   = split_data[SPLIT_W-1:THR_W];
    assign node_thr   = split_data[THR_W-1:0];
    assign node_left  = child_data[CHILD_W-1:ID_W];
    assign node_right = child_data[ID_W-1:0];
    assign last_tree  = (tree_reg + TW'(1)) == trees_reg;
    assign steps_full = steps_reg == SW'(MAX_WALK_STEPS);
    assign rd_addr    = addr_sum[MAW-1:0];
    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign match_rule = match_reg;
    assign walk_error = error_reg;

    always_comb
    begin
        if (32'(tree_count) > 32'(TREES))
        begin
            trees_sat = TW'(TREES);
        end
        else
        begin
            trees_sat = TW'(tree_count);
        end
    end

    always_comb
    begin
        case (node_sel)
            SEL_SRC_IP:   field_val = src_ip_reg;
            SEL_DST_IP:   field_val = dst_ip_reg;
            SEL_SRC_PORT: field_val = ALU_W'(src_port_reg);
            SEL_DST_PORT: field_val = ALU_W'(dst_port_reg);
            SEL_PROTOCOL: field_val = ALU_W'(protocol_reg);
            SEL_EXTRA:    field_val = ALU_W'(extra_reg);
            default:      field_val = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (classify_start && trees_sat != '0)
                begin
                    state_next = S_CHECK_IDX;
                end
            end
            S_CHECK_IDX:
            begin
                state_next = alu_rsp.borrow ? S_CHECK_ADDR : S_IDLE;
            end
            S_CHECK_ADDR:
            begin
                state_next = alu_rsp.borrow ? S_COMPARE : S_IDLE;
            end
            S_COMPARE:
            begin
                state_next = S_LEAF;
            end
            S_LEAF:
            begin
                if (alu_rsp.borrow)
                begin
                    state_next = S_MIN;
                end
                else if (steps_full)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CHECK_IDX;
                end
            end
            S_MIN:
            begin
                state_next = last_tree ? S_IDLE : S_CHECK_IDX;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        src_ip_next   = src_ip_reg;
        dst_ip_next   = dst_ip_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        protocol_next = protocol_reg;
        extra_next    = extra_reg;
        trees_next    = trees_reg;
        tree_next     = tree_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        id_next       = id_reg;
        steps_next    = steps_reg;
        pri_next      = pri_reg;
        done_next     = 1'b0;
        match_next    = match_reg;
        error_next    = error_reg;
        rd_en         = 1'b0;
        alu_req.a     = '0;
        alu_req.b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (classify_start)
                begin
                    src_ip_next   = src_ip;
                    dst_ip_next   = dst_ip;
                    src_port_next = src_port;
                    dst_port_next = dst_port;
                    protocol_next = protocol;
                    extra_next    = extra_field;
                    trees_next    = trees_sat;
                    tree_next     = '0;
                    base_next     = '0;
                    idx_next      = '0;
                    steps_next    = '0;
                    pri_next      = default_rule;
                    if (trees_sat == '0)
                    begin
                        done_next  = 1'b1;
                        match_next = default_rule;
                        error_next = 1'b0;
                    end
                end
            end
            S_CHECK_IDX:
            begin
                alu_req.a = ALU_W'(idx_reg);
                alu_req.b = ALU_W'(NODES_PER_TREE);
                if (!alu_rsp.borrow)
                begin
                    done_next  = 1'b1;
                    match_next = default_rule;
                    error_next = 1'b1;
                end
            end
            S_CHECK_ADDR:
            begin
                alu_req.a = addr_sum;
                alu_req.b = ALU_W'(MEM_DEPTH);
                if (alu_rsp.borrow)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    match_next = default_rule;
                    error_next = 1'b1;
                end
            end
            S_COMPARE:
            begin
                alu_req.a  = node_thr;
                alu_req.b  = field_val;
                id_next    = alu_rsp.borrow ? node_right : node_left;
                steps_next = steps_reg + SW'(1);
            end
            S_LEAF:
            begin
                alu_req.a = ALU_W'(id_reg);
                alu_req.b = ALU_W'(offset);
                if (!alu_rsp.borrow)
                begin
                    if (steps_full)
                    begin
                        done_next  = 1'b1;
                        match_next = default_rule;
                        error_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = alu_rsp.diff[ID_W-1:0];
                    end
                end
            end
            S_MIN:
            begin
                alu_req.a = ALU_W'(id_reg);
                alu_req.b = ALU_W'(pri_reg);
                if (alu_rsp.borrow)
                begin
                    pri_next = id_reg[RULE_W-1:0];
                end
                tree_next  = tree_reg + TW'(1);
                base_next  = base_reg + BW'(NODES_PER_TREE);
                idx_next   = '0;
                steps_next = '0;
                if (last_tree)
                begin
                    done_next  = 1'b1;
                    match_next = pri_next;
                    error_next = 1'b0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_ip_reg   <= src_ip_next;
        dst_ip_reg   <= dst_ip_next;
        src_port_reg <= src_port_next;
        dst_port_reg <= dst_port_next;
        protocol_reg <= protocol_next;
        extra_reg    <= extra_next;
        trees_reg    <= trees_next;
        tree_reg     <= tree_next;
        base_reg     <= base_next;
        idx_reg      <= idx_next;
        id_reg       <= id_next;
        steps_reg    <= steps_next;
        pri_reg      <= pri_next;
        match_reg    <= match_next;
        error_reg    <= error_next;
    end

    a_busy_from_classify: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(classify_start))
        else $error("walk started without a classify word");

    a_read_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> state_reg == S_CHECK_ADDR)
        else $error("node read outside the address check step");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while a walk is still running");

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> steps_reg <= SW'(MAX_WALK_STEPS))
        else $error("walk step count past its bound");

endmodule

// ===== rtl/core/decision_tree_packet_classifier_unit.sv =====
// Top level of the decision tree packet classifier: config, node table and walk.
//
// A node write (opcode 0) lands in the node table at the edge it is accepted and
// leaves busy low, so writes may follow each other every cycle; writes at or beyond
// TREES * NODES_PER_TREE are dropped. A classify word (opcode 1) with a nonzero tree
// count raises busy while it walks the searched trees; each node visited takes one
// node table read and four passes through the single shared subtractor (index check,
// address check, compare, leaf test), and each tree one more pass to keep the lowest
// rule. match_rule and walk_error are valid while done is high, for exactly one cycle
// after the walk ends, and are held until the next result. A tree count of zero
// yields the default rule in the cycle after acceptance. The node table is not
// cleared at reset: every node a walk can reach must be written first.
module decision_tree_packet_classifier_unit #(
    parameter int TREES          = dtc_pkg::TREES_DEFAULT,
    parameter int NODES_PER_TREE = dtc_pkg::NODES_PER_TREE_DEFAULT,
    parameter int MAX_WALK_STEPS = dtc_pkg::MAX_WALK_STEPS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [dtc_pkg::ADDR_W-1:0]  node_addr,
    input  logic [dtc_pkg::SEL_W-1:0]   node_field_sel,
    input  logic [dtc_pkg::THR_W-1:0]   node_threshold,
    input  logic [dtc_pkg::ID_W-1:0]    node_left,
    input  logic [dtc_pkg::ID_W-1:0]    node_right,
    input  logic [31:0]                 src_ip,
    input  logic [31:0]                 dst_ip,
    input  logic [15:0]                 src_port,
    input  logic [15:0]                 dst_port,
    input  logic [7:0]                  protocol,
    input  logic [7:0]                  extra_field,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [dtc_pkg::RULE_W-1:0]  cfg_data,
    output logic                        done,
    output logic [dtc_pkg::RULE_W-1:0]  match_rule,
    output logic                        walk_error
);

    import dtc_pkg::*;

    localparam int MEM_DEPTH = (TREES * NODES_PER_TREE < STORE_DEPTH) ?
                               TREES * NODES_PER_TREE : STORE_DEPTH;
    localparam int MAW       = $clog2(MEM_DEPTH);

    logic [RULE_W-1:0] default_rule_reg, default_rule_next;
    logic [TC_W-1:0]   tree_count_reg, tree_count_next;

    logic               node_we;
    logic               classify_start;
    logic               rd_en;
    logic [MAW-1:0]     rd_addr;
    logic [SPLIT_W-1:0] split_data;
    logic [CHILD_W-1:0] child_data;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    assign node_we        = start && !busy && opcode == OP_WRITE &&
                            32'(node_addr) < 32'(MEM_DEPTH);
    assign classify_start = start && !busy && opcode == OP_CLASSIFY;

    always_comb
    begin
        default_rule_next = default_rule_reg;
        tree_count_next   = tree_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DEFAULT_RULE: default_rule_next = cfg_data;
                REG_TREE_COUNT:   tree_count_next   = cfg_data[TC_W-1:0];
                default:          default_rule_next = default_rule_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_rule_reg <= '0;
            tree_count_reg   <= TC_W'(1);
        end
        else
        begin
            default_rule_reg <= default_rule_next;
            tree_count_reg   <= tree_count_next;
        end
    end

    dtc_ram #(
        .WIDTH (SPLIT_W),
        .DEPTH (MEM_DEPTH)
    ) u_split_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_addr[MAW-1:0]),
        .wdata ({node_field_sel, node_threshold}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (split_data)
    );

    dtc_ram #(
        .WIDTH (CHILD_W),
        .DEPTH (MEM_DEPTH)
    ) u_child_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_addr[MAW-1:0]),
        .wdata ({node_left, node_right}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (child_data)
    );

    dtc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    dtc_seq #(
        .TREES          (TREES),
        .NODES_PER_TREE (NODES_PER_TREE),
        .MAX_WALK_STEPS (MAX_WALK_STEPS),
        .MEM_DEPTH      (MEM_DEPTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .classify_start (classify_start),
        .src_ip         (src_ip),
        .dst_ip         (dst_ip),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .protocol       (protocol),
        .extra_field    (extra_field),
        .default_rule   (default_rule_reg),
        .tree_count     (tree_count_reg),
        .split_data     (split_data),
        .child_data     (child_data),
        .alu_rsp        (alu_rsp),
        .alu_req        (alu_req),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .busy           (busy),
        .done           (done),
        .match_rule     (match_rule),
        .walk_error     (walk_error)
    );

endmodule

// ===== bench/decision_tree_packet_classifier_unit_tb.sv =====
// Self-checking testbench for the decision tree packet classifier unit.
module decision_tree_packet_classifier_unit_tb;
    import dtc_pkg::*;

    localparam int TREE_SLOTS = TREES_DEFAULT;
    localparam int NODES      = NODES_PER_TREE_DEFAULT;
    localparam int WALK_LIMIT = MAX_WALK_STEPS_DEFAULT;
    localparam int SPAN       = 24;
    localparam int PHASES     = 10;
    localparam int PHASE_WORDS = 150;

    typedef struct {
        bit               op;
        bit [ADDR_W-1:0]  addr;
        bit [SEL_W-1:0]   sel;
        bit [THR_W-1:0]   thr;
        bit [ID_W-1:0]    left;
        bit [ID_W-1:0]    right;
        bit [31:0]        sip;
        bit [31:0]        dip;
        bit [15:0]        sport;
        bit [15:0]        dport;
        bit [7:0]         proto;
        bit [7:0]         extra;
    } word_t;

    typedef struct {
        bit [RULE_W-1:0] rule;
        bit              err;
    } verdict_t;

    typedef struct {
        bit              is_reg;
        bit              reg_idx;
        bit [RULE_W-1:0] reg_val;
        word_t           w;
        bit              typed;
        verdict_t        v;
    } row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                opcode = OP_WRITE;
    logic [ADDR_W-1:0]   node_addr = '0;
    logic [SEL_W-1:0]    node_field_sel = '0;
    logic [THR_W-1:0]    node_threshold = '0;
    logic [ID_W-1:0]     node_left = '0;
    logic [ID_W-1:0]     node_right = '0;
    logic [31:0]         src_ip = '0;
    logic [31:0]         dst_ip = '0;
    logic [15:0]         src_port = '0;
    logic [15:0]         dst_port = '0;
    logic [7:0]          protocol = '0;
    logic [7:0]          extra_field = '0;
    logic                cfg_write = 1'b0;
    logic                cfg_index = REG_DEFAULT_RULE;
    logic [RULE_W-1:0]   cfg_data = '0;
    logic                done;
    logic [RULE_W-1:0]   match_rule;
    logic                walk_error;

    bit [SEL_W-1:0]  node_sel    [STORE_DEPTH];
    bit [THR_W-1:0]  node_thr    [STORE_DEPTH];
    bit [ID_W-1:0]   node_lo     [STORE_DEPTH];
    bit [ID_W-1:0]   node_hi     [STORE_DEPTH];
    bit              node_loaded [STORE_DEPTH];
    int              rule_default = 0;
    int              tree_setting = 1;

    verdict_t        expected_matches[$];
    int              mismatch_count = 0;
    bit              no_gaps = 1'b0;

    decision_tree_packet_classifier_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .node_addr      (node_addr),
        .node_field_sel (node_field_sel),
        .node_threshold (node_threshold),
        .node_left      (node_left),
        .node_right     (node_right),
        .src_ip         (src_ip),
        .dst_ip         (dst_ip),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .protocol       (protocol),
        .extra_field    (extra_field),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .match_rule     (match_rule),
        .walk_error     (walk_error)
    );

    always #10 clk = ~clk;

    function automatic bit [31:0] header_value(word_t w, bit [SEL_W-1:0] sel);
        case (sel)
            SEL_SRC_IP:   return w.sip;
            SEL_DST_IP:   return w.dip;
            SEL_SRC_PORT: return {16'd0, w.sport};
            SEL_DST_PORT: return {16'd0, w.dport};
            SEL_PROTOCOL: return {24'd0, w.proto};
            SEL_EXTRA:    return {24'd0, w.extra};
            default:      return 32'd0;
        endcase
    endfunction

    function automatic int active_trees();
        return (tree_setting > TREE_SLOTS) ? TREE_SLOTS : tree_setting;
    endfunction

    // Returns 1 when a leaf is reached; hole names an unloaded node the walk would read.
    function automatic bit walk_tree(word_t w, int tree, output int leaf, output int hole);
        int offset;
        int id;
        int idx;
        int addr;
        bit [ADDR_W-1:0] slot;
        offset = rule_default + 1;
        id = offset;
        leaf = 0;
        hole = -1;
        for (int step = 0; step < WALK_LIMIT; step++) begin
            idx = id - offset;
            if (idx >= NODES)
                return 1'b0;
            addr = tree * NODES + idx;
            if (addr >= STORE_DEPTH)
                return 1'b0;
            slot = ADDR_W'(addr);
            if (!node_loaded[slot]) begin
                hole = addr;
                return 1'b0;
            end
            id = (header_value(w, node_sel[slot]) <= node_thr[slot]) ?
                 int'(node_lo[slot]) : int'(node_hi[slot]);
            if (id < offset) begin
                leaf = id;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int find_hole(word_t w);
        int leaf;
        int hole;
        for (int t = 0; t < active_trees(); t++) begin
            void'(walk_tree(w, t, leaf, hole));
            if (hole >= 0)
                return hole;
        end
        return -1;
    endfunction

    function automatic verdict_t lookup_rule(word_t w);
        verdict_t v;
        int leaf;
        int hole;
        int best;
        best = rule_default;
        v.err = 1'b0;
        for (int t = 0; t < active_trees(); t++) begin
            if (!walk_tree(w, t, leaf, hole)) begin
                v.err = 1'b1;
                break;
            end
            if (leaf < best)
                best = leaf;
        end
        v.rule = v.err ? rule_default[RULE_W-1:0] : best[RULE_W-1:0];
        return v;
    endfunction

    function automatic void store_node(word_t w);
        if (int'(w.addr) < TREE_SLOTS * NODES) begin
            node_sel[w.addr]    = w.sel;
            node_thr[w.addr]    = w.thr;
            node_lo[w.addr]     = w.left;
            node_hi[w.addr]     = w.right;
            node_loaded[w.addr] = 1'b1;
        end
    endfunction

    function automatic bit [31:0] rand_upto(bit [31:0] top);
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic word_t random_word();
        word_t w;
        w.op    = 1'($urandom_range(0, 1));
        w.addr  = ADDR_W'($urandom);
        w.sel   = SEL_W'($urandom);
        w.thr   = $urandom;
        w.left  = ID_W'($urandom);
        w.right = ID_W'($urandom);
        w.sip   = rand_upto(32'hFFFF_FFFF);
        w.dip   = rand_upto(32'hFFFF_FFFF);
        w.sport = 16'(rand_upto(32'hFFFF));
        w.dport = 16'(rand_upto(32'hFFFF));
        w.proto = 8'(rand_upto(32'hFF));
        w.extra = 8'(rand_upto(32'hFF));
        return w;
    endfunction

    function automatic bit [ID_W-1:0] pick_child(int idx);
        int top;
        if ($urandom_range(0, 19) == 0)
            return ($urandom_range(0, 1) == 1) ? {ID_W{1'b1}} :
                   ID_W'(rule_default + 1 + NODES + $urandom_range(0, 3));
        if (idx >= SPAN - 1 || $urandom_range(0, 9) < 4)
            return ID_W'(rand_upto(rule_default));
        top = (idx + 4 < SPAN - 1) ? idx + 4 : SPAN - 1;
        return ID_W'(rule_default + 1 + $urandom_range(idx + 1, top));
    endfunction

    function automatic word_t make_node(int addr);
        word_t w;
        w = random_word();
        w.op = OP_WRITE;
        w.addr = ADDR_W'(addr);
        w.sel = SEL_W'(($urandom_range(0, 9) < 9) ? $urandom_range(0, 5) :
                                                    $urandom_range(6, 7));
        case (w.sel)
            SEL_SRC_IP, SEL_DST_IP:     w.thr = rand_upto(32'hFFFF_FFFF);
            SEL_SRC_PORT, SEL_DST_PORT: w.thr = rand_upto(32'hFFFF);
            SEL_PROTOCOL, SEL_EXTRA:    w.thr = rand_upto(32'hFF);
            default:                    w.thr = $urandom;
        endcase
        w.left  = pick_child(addr % NODES);
        w.right = pick_child(addr % NODES);
        return w;
    endfunction

    function automatic row_t row_reg(bit idx, int val);
        row_t r;
        r = '{default: 0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = RULE_W'(val);
        return r;
    endfunction

    function automatic row_t row_node(int addr, bit [SEL_W-1:0] sel, bit [31:0] thr,
                                      int lft, int rgt);
        row_t r;
        r = '{default: 0};
        r.w.op    = OP_WRITE;
        r.w.addr  = ADDR_W'(addr);
        r.w.sel   = sel;
        r.w.thr   = thr;
        r.w.left  = ID_W'(lft);
        r.w.right = ID_W'(rgt);
        return r;
    endfunction

    function automatic row_t row_pkt(bit [31:0] sip, bit [31:0] dip, bit [15:0] sport,
                                     bit [15:0] dport, bit [7:0] proto, bit [7:0] extra,
                                     bit typed, int rule, bit err);
        row_t r;
        r = '{default: 0};
        r.w.op    = OP_CLASSIFY;
        r.w.sip   = sip;
        r.w.dip   = dip;
        r.w.sport = sport;
        r.w.dport = dport;
        r.w.proto = proto;
        r.w.extra = extra;
        r.typed   = typed;
        r.v.rule  = RULE_W'(rule);
        r.v.err   = err;
        return r;
    endfunction

    task automatic issue(word_t w, bit typed, verdict_t tv);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        opcode         <= w.op;
        node_addr      <= w.addr;
        node_field_sel <= w.sel;
        node_threshold <= w.thr;
        node_left      <= w.left;
        node_right     <= w.right;
        src_ip         <= w.sip;
        dst_ip         <= w.dip;
        src_port       <= w.sport;
        dst_port       <= w.dport;
        protocol       <= w.proto;
        extra_field    <= w.extra;
        do
            @(posedge clk);
        while (busy);
        if (w.op == OP_WRITE)
            store_node(w);
        else
            expected_matches.push_back(typed ? tv : lookup_rule(w));
    endtask

    // Load every node the walk would reach before the packet goes in.
    task automatic send_packet(word_t w, bit typed, verdict_t tv);
        int hole;
        verdict_t none;
        none = '{default: 0};
        hole = find_hole(w);
        while (hole >= 0) begin
            issue(make_node(hole), 1'b0, none);
            hole = find_hole(w);
        end
        issue(w, typed, tv);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(bit idx, int val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= RULE_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_DEFAULT_RULE)
            rule_default = val & 16'hFFFF;
        else
            tree_setting = val & 7;
    endtask

    // Straight chain from the root of tree 0: len nodes, then a leaf.
    task automatic build_chain(int len);
        word_t w;
        verdict_t none;
        none = '{default: 0};
        for (int k = 0; k < len; k++) begin
            w = random_word();
            w.op = OP_WRITE;
            w.addr = ADDR_W'(k);
            w.left = (k == len - 1) ? ID_W'($urandom_range(0, rule_default)) :
                     ID_W'(rule_default + 2 + k);
            w.right = w.left;
            issue(w, 1'b0, none);
        end
        repeat (3) begin
            w = random_word();
            w.op = OP_CLASSIFY;
            send_packet(w, 1'b0, none);
        end
    endtask

    always @(posedge clk) begin : check_results
        verdict_t v;
        if (rst_n && done) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected result word: match_rule %0d walk_error %0b",
                       match_rule, walk_error);
                mismatch_count++;
            end else begin
                v = expected_matches.pop_front();
                if (match_rule !== v.rule) begin
                    $error("match_rule: expected %0d, got %0d", v.rule, match_rule);
                    mismatch_count++;
                end
                if (walk_error !== v.err) begin
                    $error("walk_error: expected %0b, got %0b", v.err, walk_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        row_t     plan[$];
        row_t     r;
        word_t    w;
        verdict_t none;
        int       phase_rule[PHASES];
        int       phase_trees[PHASES];
        int       pick;

        none = '{default: 0};
        plan.push_back(row_node(0, SEL_SRC_IP, 32'd0, 0, 0));
        plan.push_back(row_pkt(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
        plan.push_back(row_node(0, SEL_SRC_IP, 32'd0, 1, 0));
        plan.push_back(row_pkt(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b1));
        plan.push_back(row_pkt('1, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
        plan.push_back(row_reg(REG_DEFAULT_RULE, 100));
        plan.push_back(row_reg(REG_TREE_COUNT, 4));
        plan.push_back(row_node(0, SEL_SRC_IP, 32'hFFFF_FFFF, 102, 131071));
        plan.push_back(row_node(1, SEL_DST_IP, 32'd0, 7, 100));
        plan.push_back(row_node(4096, SEL_SRC_PORT, 32'hFFFF, 20, 5));
        plan.push_back(row_node(8192, 3'd6, 32'd0, 30, 1));
        plan.push_back(row_node(12288, SEL_EXTRA, 32'h80, 4196, 4197));
        plan.push_back(row_node(16383, SEL_PROTOCOL, 32'hFF, 2, 2));
        plan.push_back(row_pkt(0, 0, 0, 0, 0, 8'h80, 1'b0, 0, 1'b0));
        plan.push_back(row_pkt(0, '1, 0, 0, 0, 8'hFF, 1'b1, 100, 1'b1));
        plan.push_back(row_pkt(0, '1, '1, 0, '1, 8'h80, 1'b0, 0, 1'b0));
        plan.push_back(row_reg(REG_TREE_COUNT, 7));
        plan.push_back(row_pkt(0, 0, 0, 0, 0, 8'hFF, 1'b1, 100, 1'b1));
        plan.push_back(row_reg(REG_TREE_COUNT, 0));
        plan.push_back(row_pkt('1, '1, '1, '1, '1, '1, 1'b1, 100, 1'b0));
        plan.push_back(row_reg(REG_DEFAULT_RULE, 65534));
        plan.push_back(row_reg(REG_TREE_COUNT, 1));
        plan.push_back(row_pkt(5, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
        plan.push_back(row_node(4095, SEL_DST_PORT, 32'd0, 0, 65535));
        plan.push_back(row_node(0, SEL_SRC_IP, 32'd0, 65534, 69630));
        plan.push_back(row_pkt(0, 0, 0, 0, 0, 0, 1'b1, 65534, 1'b0));
        plan.push_back(row_pkt(1, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
        plan.push_back(row_pkt(1, 0, 0, '1, 0, 0, 1'b1, 65534, 1'b1));

        phase_rule  = '{0, 100, 65534, 7, 1000, 30000, 65534,
                        $urandom_range(1, 65533), 0, $urandom_range(1, 65533)};
        phase_trees = '{1, 4, 2, 3, 7, 0, 4, 4, 4, $urandom_range(1, 4)};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.is_reg)
                write_reg(r.reg_idx, int'(r.reg_val));
            else if (r.w.op == OP_CLASSIFY)
                send_packet(r.w, r.typed, r.v);
            else
                issue(r.w, 1'b0, none);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_DEFAULT_RULE, phase_rule[p]);
            write_reg(REG_TREE_COUNT, phase_trees[p]);
            no_gaps = (p % 3 == 2);
            if (p == 1) begin
                build_chain(WALK_LIMIT);
                build_chain(WALK_LIMIT + 1);
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    issue(make_node($urandom_range(0, TREE_SLOTS - 1) * NODES +
                                    $urandom_range(0, SPAN - 1)), 1'b0, none);
                end else if (pick < 27) begin
                    w = random_word();
                    w.op = OP_WRITE;
                    issue(w, 1'b0, none);
                end else begin
                    w = random_word();
                    w.op = OP_CLASSIFY;
                    send_packet(w, 1'b0, none);
                end
                if ($urandom_range(0, 63) == 0)
                    drain();
            end
        end

        drain();
        repeat (600) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
